// ===== rtl/crrt_pkg.sv =====
// shared types, codes and sizes for the clock rate residency table
package crrt_pkg;

   localparam int RATE_W   = 31;
   localparam int TIME_W   = 64;
   localparam int PREV_W   = 32;
   localparam int INDEX_W  = 6;
   localparam int CNT_W    = 7;
   localparam int MODE_W   = 2;

   localparam int DEFAULT_TABLE_DEPTH = 64;

   localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RATE   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam logic [PREV_W-1:0] PREV_RATE_RESET = {PREV_W{1'b1}};

   localparam logic ALU_ADD = 1'b0;
   localparam logic ALU_SUB = 1'b1;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [INDEX_W-1:0] entry_index;
      logic [RATE_W-1:0]  rate_value;
      logic [TIME_W-1:0]  now;
   } req_type;

   typedef struct packed {
      logic [RATE_W-1:0] read_rate;
      logic [TIME_W-1:0] read_time;
      logic              old_rate_matched;
      logic              status;
   } rsp_type;

endpackage

// ===== rtl/clock_rate_residency_table.sv =====
// top level of the clock rate residency table
// usage
//   req_*  : request channel (valid/stall), payload req_data of crrt_pkg::req_type
//   rsp_*  : result channel (valid/stall), one result per request, in order
//   csr_*  : write channel for entries_in_use (valid/ready), the user writes only while idle, not enforced
// sequencer states from acceptance to the result, with
// n = min(entries_in_use, TABLE_DEPTH)
//   load entry / unused mode  : load, finish / finish
//   rate change               : span, scan of n entries, finish
//   close interval and read   : as a rate change plus an entry read, except for an index out of range
//   the scan reads one entry per cycle through one memory port and one shared adder
//   req_stall is high from acceptance until the result is loaded into the
//   output register; a waiting result does not block the next request
// reset
//   synchronous, clears the sequencer, entries_in_use, the current rate
//   (to a value that matches no entry) and the last update time; the table
//   contents are undefined until loaded
// stall
//   the result stays in the output register while rsp_stall is high; a
//   finished request waits there until the register frees up
module clock_rate_residency_table #(
   parameter int TABLE_DEPTH = crrt_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  crrt_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output crrt_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [crrt_pkg::CNT_W-1:0]     csr_data
);
   import crrt_pkg::*;

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_LOAD    = 3'd1;
   localparam logic [2:0] ST_SPAN    = 3'd2;
   localparam logic [2:0] ST_SCAN    = 3'd3;
   localparam logic [2:0] ST_RD_ADDR = 3'd4;
   localparam logic [2:0] ST_FINISH  = 3'd5;

   logic [RATE_W-1:0] rate_mem [TABLE_DEPTH];
   logic [TIME_W-1:0] time_mem [TABLE_DEPTH];

   logic [2:0]        state_ff, state_in;
   req_type           item_ff, item_in;
   logic              ok_ff, ok_in;
   logic [TIME_W-1:0] span_ff, span_in;
   logic [TIME_W-1:0] last_ff, last_in;
   logic [PREV_W-1:0] prev_ff, prev_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic              hit_ff, hit_in;
   logic [CNT_W-1:0]  cfg_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic [RATE_W-1:0] rate_rd_ff;
   logic [TIME_W-1:0] time_rd_ff;

   logic [CNT_W-1:0]  n_w;
   logic              req_take;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              time_we;
   logic              rate_we;
   logic [ADDR_W-1:0] wr_addr;
   logic [TIME_W-1:0] time_wdata;
   logic              alu_op;
   logic [TIME_W-1:0] alu_a;
   logic [TIME_W-1:0] alu_b;
   logic [TIME_W-1:0] alu_result;
   logic              alu_equal;
   logic              out_free;

   assign n_w = (32'(cfg_ff) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : cfg_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   crrt_alu u_alu (
      .op     (alu_op),
      .a      (alu_a),
      .b      (alu_b),
      .cmp_a  ({1'b0, rate_rd_ff}),
      .cmp_b  (prev_ff),
      .result (alu_result),
      .equal  (alu_equal)
   );

   always_comb begin
      if (state_ff == ST_SPAN) begin
         alu_op = ALU_SUB;
         alu_a  = item_ff.now;
         alu_b  = last_ff;
      end else begin
         alu_op = ALU_ADD;
         alu_a  = time_rd_ff;
         alu_b  = span_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      ok_in        = ok_ff;
      span_in      = span_ff;
      last_in      = last_ff;
      prev_in      = prev_ff;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = ADDR_W'(item_ff.entry_index);
      time_we      = 1'b0;
      rate_we      = 1'b0;
      wr_addr      = ADDR_W'(item_ff.entry_index);
      time_wdata   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               item_in = req_data;
               ok_in   = ({1'b0, req_data.entry_index} < n_w);
               hit_in  = 1'b0;
               cnt_in  = '0;
               case (req_data.mode)
                  MODE_LOAD:   state_in = ST_LOAD;
                  MODE_RATE:   state_in = ST_SPAN;
                  MODE_READ:   state_in = ST_SPAN;
                  MODE_UNUSED: state_in = ST_FINISH;
                  default:     state_in = ST_FINISH;
               endcase
            end
         end
         ST_LOAD: begin
            time_we  = ok_ff;
            rate_we  = ok_ff;
            state_in = ST_FINISH;
         end
         ST_SPAN: begin
            span_in  = alu_result;
            last_in  = item_ff.now;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (cnt_ff < n_w) begin
               rd_en        = 1'b1;
               rd_addr      = ADDR_W'(cnt_ff);
               pend_in      = 1'b1;
               pend_addr_in = ADDR_W'(cnt_ff);
               cnt_in       = cnt_ff + CNT_W'(1);
            end
            if (pend_ff && alu_equal) begin
               time_we    = 1'b1;
               wr_addr    = pend_addr_ff;
               time_wdata = alu_result;
               hit_in     = 1'b1;
            end
            if (cnt_ff == n_w && !pend_ff) begin
               if (item_ff.mode == MODE_RATE) begin
                  prev_in  = {1'b0, item_ff.rate_value};
                  state_in = ST_FINISH;
               end else if (ok_ff) begin
                  state_in = ST_RD_ADDR;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_RD_ADDR: begin
            rd_en    = 1'b1;
            rd_addr  = ADDR_W'(item_ff.entry_index);
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in                  = '0;
               rsp_data_in.old_rate_matched = hit_ff && (item_ff.mode == MODE_RATE
                                              || item_ff.mode == MODE_READ);
               rsp_data_in.status           = !ok_ff && (item_ff.mode == MODE_LOAD
                                              || item_ff.mode == MODE_READ);
               if (item_ff.mode == MODE_READ && ok_ff) begin
                  rsp_data_in.read_rate = rate_rd_ff;
                  rsp_data_in.read_time = time_rd_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // table storage
   always_ff @(posedge clock) begin
      if (rate_we) begin
         rate_mem[wr_addr] <= item_ff.rate_value;
      end
      if (rd_en) begin
         rate_rd_ff <= rate_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (time_we) begin
         time_mem[wr_addr] <= time_wdata;
      end
      if (rd_en) begin
         time_rd_ff <= time_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      ok_ff        <= ok_in;
      span_ff      <= span_in;
      pend_addr_ff <= pend_addr_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_ff      <= '0;
         prev_ff      <= PREV_RATE_RESET;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         cfg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         prev_ff      <= prev_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            cfg_ff <= csr_data;
         end
      end
   end

endmodule

// ===== rtl/crrt_alu.sv =====
// shared 64-bit add/subtract unit with rate equality compare
module crrt_alu (
   input  logic                          op,
   input  logic [crrt_pkg::TIME_W-1:0]   a,
   input  logic [crrt_pkg::TIME_W-1:0]   b,
   input  logic [crrt_pkg::PREV_W-1:0]   cmp_a,
   input  logic [crrt_pkg::PREV_W-1:0]   cmp_b,
   output logic [crrt_pkg::TIME_W-1:0]   result,
   output logic                          equal
);
   import crrt_pkg::*;

   logic [TIME_W-1:0] b_op;

   always_comb begin
      case (op)
         ALU_ADD: b_op = b;
         ALU_SUB: b_op = ~b;
         default: b_op = b;
      endcase
   end

   assign result = a + b_op + {{(TIME_W-1){1'b0}}, op};
   assign equal  = (cmp_a == cmp_b);

endmodule

// ===== rtl/crrt_checker.sv =====
// port-level checks for the clock rate residency table, bound to the top level
module crrt_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input crrt_pkg::rsp_type          rsp_data,
   input logic                       csr_valid,
   input logic                       csr_ready
);
   import crrt_pkg::*;

   logic req_fire;

   assign req_fire = req_valid && !req_stall;

   // a held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // one request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> req_stall)
      else $error("request taken while busy");

   // no result in the cycle straight after a request is taken
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // a refused index returns no table contents
   a_status_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |-> rsp_data.read_rate == '0
                                       && rsp_data.read_time == '0)
      else $error("data returned with bad index status");

   // the register port never refuses a write
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write refused");

endmodule

bind clock_rate_residency_table crrt_checker u_crrt_checker (.*);
